@@ sv/lru_block_cache_with_byte_budget_macros.svh @@
// Assertion macros for the LRU block cache.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LRU_BLOCK_CACHE_WITH_BYTE_BUDGET_MACROS_SVH
`define LRU_BLOCK_CACHE_WITH_BYTE_BUDGET_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LRUBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LRUBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lrubc_pkg.sv @@
// Types, codes and sizes shared by the LRU block cache.
// No dependencies.
package lrubc_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [31:0] CAP_RESET   = 32'd8388608;
    localparam logic [8:0]  REMOVED_MAX = 9'd511;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] file_id;
        logic [39:0] block_offset;
        logic [31:0] value_id;
        logic [20:0] block_bytes;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [8:0]  evicted_now;
        logic [31:0] total_charge;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0]      file;
        logic [39:0]      offset;
        logic [31:0]      value;
        logic [20:0]      charge;
        logic [IDX_W-1:0] rank;
    } entry_t;

    typedef struct packed {
        logic key_eq;
        logic file_eq;
        logic is_oldest;
        logic is_free;
    } scan_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_ADJUST,
        ST_WRITE,
        ST_EVCHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADJ_INC_BELOW,
        ADJ_INC_ALL,
        ADJ_DEC_ABOVE
    } adj_t;

endpackage

@@ sv/lrubc_match.sv @@
// Entry compare unit of the LRU block cache, used by the scan sweep.
// Depends on lrubc_pkg.
module lrubc_match (
    input  lrubc_pkg::entry_t                entry,
    input  logic                             entry_valid,
    input  logic [31:0]                      file_id,
    input  logic [39:0]                      block_offset,
    input  logic [lrubc_pkg::IDX_W-1:0]      last_rank,
    output lrubc_pkg::scan_flags_t           flags
);
    import lrubc_pkg::*;

    logic file_eq;

    assign file_eq         = entry_valid && (entry.file == file_id);
    assign flags.file_eq   = file_eq;
    assign flags.key_eq    = file_eq && (entry.offset == block_offset);
    assign flags.is_oldest = entry_valid && (entry.rank == last_rank);
    assign flags.is_free   = !entry_valid;

endmodule

@@ sv/lru_block_cache_with_byte_budget.sv @@
// Top level of the LRU block cache with a byte budget.
// Depends on lrubc_pkg, lrubc_match and the assertion macro header.
//
// Requests enter on req with req_valid; an item is taken when req_valid is
// high and req_stall is low. One result item leaves on rsp with rsp_valid and
// is taken when rsp_stall is low. The byte budget is written through
// cfg_valid/cfg_data; cfg_ready is always high.
// Each item is handled alone by a sequencer that sweeps the entry memory
// through one read port, one entry a cycle. A lookup miss takes one scan sweep,
// a hit a scan and a rank-adjust sweep. Insert of a new key takes a scan, an
// adjust sweep and a write, then one more scan per budget eviction. Erase
// takes a scan and an adjust sweep per entry erased, then a final scan.
// req_stall is high while an item is at work; the next item can be taken in the
// cycle after the result is loaded. The result waits in an output register,
// so a new item can be taken while the receiver stalls; the next result
// waits until that register empties.
// Reset clears all valid bits, the counters and the total at once, and sets
// the budget to 8388608 bytes; no clearing pass is needed.
module lru_block_cache_with_byte_budget (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  lrubc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output lrubc_pkg::rsp_t   rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import lrubc_pkg::*;
    `include "lru_block_cache_with_byte_budget_macros.svh"

    entry_t mem [ENTRIES];
    entry_t rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;

    state_t state_reg, state_next;
    req_t req_reg, req_next;
    logic [31:0] cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic valid_reg [ENTRIES];
    logic set_en, clr_en;
    logic [IDX_W-1:0] set_idx, clr_idx;
    logic [CNT_W-1:0] sweep_reg, sweep_next;
    logic p_valid_reg, p_valid_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;
    logic sweeping, sweep_done;

    logic match_hit_reg, match_hit_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic [IDX_W-1:0] match_rank_reg, match_rank_next;
    logic [31:0] match_value_reg, match_value_next;
    logic efound_reg, efound_next;
    logic [IDX_W-1:0] eslot_reg, eslot_next;
    logic [IDX_W-1:0] erank_reg, erank_next;
    logic [20:0] echarge_reg, echarge_next;
    logic [IDX_W-1:0] old_slot_reg, old_slot_next;
    logic [20:0] old_charge_reg, old_charge_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;

    logic evict_phase_reg, evict_phase_next;
    adj_t adj_mode_reg, adj_mode_next;
    logic [IDX_W-1:0] adj_rank_reg, adj_rank_next;
    logic tgt_en_reg, tgt_en_next;
    logic [IDX_W-1:0] tgt_slot_reg, tgt_slot_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [32:0] t_reg, t_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] hits_reg, hits_next;
    logic [31:0] misses_reg, misses_next;
    logic [31:0] evict_reg, evict_next;
    logic [8:0] removed_reg, removed_next;
    logic found_reg, found_next;
    logic [31:0] vout_reg, vout_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic accept, rsp_free, full, over_budget;
    logic [IDX_W-1:0] last_rank;
    logic [8:0] removed_inc;
    scan_flags_t flags;
    logic [IDX_W-1:0] new_rank;

    assign accept      = req_valid && (state_reg == ST_IDLE);
    assign req_stall   = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign full        = (count_reg == CNT_W'(ENTRIES));
    assign last_rank   = IDX_W'(count_reg - 1'b1);
    assign removed_inc = (removed_reg == REMOVED_MAX) ? removed_reg : removed_reg + 9'd1;
    assign over_budget = (t_reg > {1'b0, cap_reg}) && (count_reg > CNT_W'(1));
    assign sweeping    = (state_reg == ST_SCAN) || (state_reg == ST_ADJUST);
    assign sweep_done  = (sweep_reg == CNT_W'(ENTRIES)) && !p_valid_reg;
    assign rd_addr     = sweep_reg[IDX_W-1:0];

    lrubc_match u_match (
        .entry        (rd_reg),
        .entry_valid  (valid_reg[p_idx_reg]),
        .file_id      (req_reg.file_id),
        .block_offset (req_reg.block_offset),
        .last_rank    (last_rank),
        .flags        (flags)
    );

    always_comb
    begin
        new_rank = rd_reg.rank;
        if (tgt_en_reg && (p_idx_reg == tgt_slot_reg))
        begin
            new_rank = '0;
        end
        else
        begin
            unique case (adj_mode_reg)
                ADJ_INC_BELOW:
                begin
                    if (rd_reg.rank < adj_rank_reg)
                        new_rank = rd_reg.rank + 1'b1;
                end
                ADJ_INC_ALL:
                begin
                    new_rank = rd_reg.rank + 1'b1;
                end
                ADJ_DEC_ABOVE:
                begin
                    if (rd_reg.rank > adj_rank_reg)
                        new_rank = rd_reg.rank - 1'b1;
                end
                default:
                begin
                    new_rank = rd_reg.rank;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sweep_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (evict_phase_reg)
                    state_next = ST_EVCHK;
                else if (req_reg.action == ACT_LOOKUP)
                    state_next = match_hit_reg ? ST_ADJUST : ST_DONE;
                else if (req_reg.action == ACT_INSERT)
                    state_next = ST_ADJUST;
                else if (req_reg.action == ACT_ERASE)
                    state_next = efound_reg ? ST_ADJUST : ST_DONE;
                else
                    state_next = ST_DONE;
            end
            ST_ADJUST:
            begin
                if (sweep_done)
                begin
                    if (req_reg.action == ACT_ERASE)
                        state_next = ST_SCAN;
                    else if (found_reg)
                        state_next = ST_DONE;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_EVCHK;
            end
            ST_EVCHK:
            begin
                state_next = over_budget ? ST_SCAN : ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next = req_reg;
        count_next = count_reg;
        set_en = 1'b0;
        set_idx = slot_reg;
        clr_en = 1'b0;
        clr_idx = old_slot_reg;
        sweep_next = '0;
        p_valid_next = 1'b0;
        p_idx_next = rd_addr;
        match_hit_next = match_hit_reg;
        match_slot_next = match_slot_reg;
        match_rank_next = match_rank_reg;
        match_value_next = match_value_reg;
        efound_next = efound_reg;
        eslot_next = eslot_reg;
        erank_next = erank_reg;
        echarge_next = echarge_reg;
        old_slot_next = old_slot_reg;
        old_charge_next = old_charge_reg;
        free_slot_next = free_slot_reg;
        evict_phase_next = evict_phase_reg;
        adj_mode_next = adj_mode_reg;
        adj_rank_next = adj_rank_reg;
        tgt_en_next = tgt_en_reg;
        tgt_slot_next = tgt_slot_reg;
        slot_next = slot_reg;
        t_next = t_reg;
        total_next = total_reg;
        hits_next = hits_reg;
        misses_next = misses_reg;
        evict_next = evict_reg;
        removed_next = removed_reg;
        found_next = found_reg;
        vout_next = vout_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we = 1'b0;
        mem_waddr = p_idx_reg;
        mem_wdata = rd_reg;

        if (sweeping)
        begin
            if (sweep_done)
            begin
                sweep_next = '0;
            end
            else if (sweep_reg != CNT_W'(ENTRIES))
            begin
                sweep_next = sweep_reg + 1'b1;
                p_valid_next = 1'b1;
            end
            else
            begin
                sweep_next = sweep_reg;
            end
        end

        if ((state_reg != ST_SCAN) && (state_reg != ST_DECIDE))
        begin
            match_hit_next = 1'b0;
            efound_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    removed_next = '0;
                    found_next = 1'b0;
                    vout_next = '0;
                    evict_phase_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (p_valid_reg)
                begin
                    if (flags.key_eq)
                    begin
                        match_hit_next = 1'b1;
                        match_slot_next = p_idx_reg;
                        match_rank_next = rd_reg.rank;
                        match_value_next = rd_reg.value;
                    end
                    if (flags.file_eq)
                    begin
                        efound_next = 1'b1;
                        eslot_next = p_idx_reg;
                        erank_next = rd_reg.rank;
                        echarge_next = rd_reg.charge;
                    end
                    if (flags.is_oldest)
                    begin
                        old_slot_next = p_idx_reg;
                        old_charge_next = rd_reg.charge;
                    end
                    if (flags.is_free)
                        free_slot_next = p_idx_reg;
                end
            end
            ST_DECIDE:
            begin
                if (evict_phase_reg)
                begin
                    clr_en = 1'b1;
                    clr_idx = old_slot_reg;
                    t_next = t_reg - {12'd0, old_charge_reg};
                    count_next = count_reg - 1'b1;
                    removed_next = removed_inc;
                    evict_next = evict_reg + 32'd1;
                end
                else if ((req_reg.action == ACT_LOOKUP) || (req_reg.action == ACT_INSERT))
                begin
                    if (match_hit_reg)
                    begin
                        if (req_reg.action == ACT_LOOKUP)
                            hits_next = hits_reg + 32'd1;
                        found_next = 1'b1;
                        vout_next = match_value_reg;
                        adj_mode_next = ADJ_INC_BELOW;
                        adj_rank_next = match_rank_reg;
                        tgt_en_next = 1'b1;
                        tgt_slot_next = match_slot_reg;
                    end
                    else if (req_reg.action == ACT_LOOKUP)
                    begin
                        misses_next = misses_reg + 32'd1;
                    end
                    else
                    begin
                        adj_mode_next = ADJ_INC_ALL;
                        tgt_en_next = 1'b0;
                        if (full)
                        begin
                            clr_en = 1'b1;
                            clr_idx = old_slot_reg;
                            total_next = total_reg - {11'd0, old_charge_reg};
                            count_next = count_reg - 1'b1;
                            removed_next = removed_inc;
                            evict_next = evict_reg + 32'd1;
                            slot_next = old_slot_reg;
                        end
                        else
                        begin
                            slot_next = free_slot_reg;
                        end
                    end
                end
                else if ((req_reg.action == ACT_ERASE) && efound_reg)
                begin
                    clr_en = 1'b1;
                    clr_idx = eslot_reg;
                    total_next = total_reg - {11'd0, echarge_reg};
                    count_next = count_reg - 1'b1;
                    removed_next = removed_inc;
                    adj_mode_next = ADJ_DEC_ABOVE;
                    adj_rank_next = erank_reg;
                    tgt_en_next = 1'b0;
                end
            end
            ST_ADJUST:
            begin
                if (p_valid_reg && valid_reg[p_idx_reg])
                begin
                    mem_we = 1'b1;
                    mem_waddr = p_idx_reg;
                    mem_wdata = rd_reg;
                    mem_wdata.rank = new_rank;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata.file = req_reg.file_id;
                mem_wdata.offset = req_reg.block_offset;
                mem_wdata.value = req_reg.value_id;
                mem_wdata.charge = req_reg.block_bytes;
                mem_wdata.rank = '0;
                set_en = 1'b1;
                set_idx = slot_reg;
                count_next = count_reg + 1'b1;
                t_next = {1'b0, total_reg} + {12'd0, req_reg.block_bytes};
                vout_next = req_reg.value_id;
            end
            ST_EVCHK:
            begin
                if (over_budget)
                begin
                    evict_phase_next = 1'b1;
                end
                else
                begin
                    evict_phase_next = 1'b0;
                    total_next = t_reg[31:0];
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.found = found_reg;
                    rsp_next.value_out = vout_reg;
                    rsp_next.evicted_now = removed_reg;
                    rsp_next.total_charge = total_reg;
                    rsp_next.hit_count = hits_reg;
                    rsp_next.miss_count = misses_reg;
                    rsp_next.eviction_count = evict_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (clr_en)
                valid_reg[clr_idx] <= 1'b0;
            if (set_en)
                valid_reg[set_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg <= CAP_RESET;
            count_reg <= '0;
            sweep_reg <= '0;
            p_valid_reg <= 1'b0;
            match_hit_reg <= 1'b0;
            efound_reg <= 1'b0;
            evict_phase_reg <= 1'b0;
            tgt_en_reg <= 1'b0;
            total_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
            evict_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            count_reg <= count_next;
            sweep_reg <= sweep_next;
            p_valid_reg <= p_valid_next;
            match_hit_reg <= match_hit_next;
            efound_reg <= efound_next;
            evict_phase_reg <= evict_phase_next;
            tgt_en_reg <= tgt_en_next;
            total_reg <= total_next;
            hits_reg <= hits_next;
            misses_reg <= misses_next;
            evict_reg <= evict_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        p_idx_reg <= p_idx_next;
        match_slot_reg <= match_slot_next;
        match_rank_reg <= match_rank_next;
        match_value_reg <= match_value_next;
        eslot_reg <= eslot_next;
        erank_reg <= erank_next;
        echarge_reg <= echarge_next;
        old_slot_reg <= old_slot_next;
        old_charge_reg <= old_charge_next;
        free_slot_reg <= free_slot_next;
        adj_mode_reg <= adj_mode_next;
        adj_rank_reg <= adj_rank_next;
        tgt_slot_reg <= tgt_slot_next;
        slot_reg <= slot_next;
        t_reg <= t_next;
        removed_reg <= removed_next;
        found_reg <= found_next;
        vout_reg <= vout_next;
        rsp_reg <= rsp_next;
    end

    `LRUBC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES),
                      "entry count overflow")
    `LRUBC_ASSERT_NOW(a_write_free, state_reg == ST_WRITE,
                      !valid_reg[slot_reg] && !full, "insert slot not free")
    `LRUBC_ASSERT_NEXT(a_rsp_load, (state_reg == ST_DONE) && rsp_free,
                       rsp_valid_reg && (state_reg == ST_IDLE), "result not loaded")
    `LRUBC_ASSERT_NOW(a_evict_target, (state_reg == ST_DECIDE) && evict_phase_reg,
                      count_reg > CNT_W'(1), "eviction with one entry left")

endmodule

@@ tb/lru_block_cache_with_byte_budget_checker.sv @@
// Checker for the LRU block cache: it watches the request, result and budget channels.
// It predicts every result from its own copy of the cache and compares it field by field.
// Depends on lrubc_pkg.
`timescale 1ns / 100ps

module lru_block_cache_with_byte_budget_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  lrubc_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  lrubc_pkg::rsp_t rsp,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [31:0]     cfg_data,
    output int              fail_count,
    output int              outstanding
);
    import lrubc_pkg::*;

    logic        ent_live  [ENTRIES];
    logic [31:0] ent_file  [ENTRIES];
    logic [39:0] ent_off   [ENTRIES];
    logic [31:0] ent_value [ENTRIES];
    logic [20:0] ent_bytes [ENTRIES];
    int          ent_age   [ENTRIES];
    logic [31:0] budget;
    logic [31:0] resident_bytes;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
    rsp_t        awaited_rsp [$];

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ent_live[i] = 1'b0;
            ent_age[i]  = 0;
        end
        budget         = CAP_RESET;
        resident_bytes = '0;
        hit_total      = '0;
        miss_total     = '0;
        evict_total    = '0;
        fail_count     = 0;
    end

    assign outstanding = awaited_rsp.size();

    function automatic int find_key(logic [31:0] f, logic [39:0] o);
        for (int i = 0; i < ENTRIES; i++)
            if (ent_live[i] && ent_file[i] == f && ent_off[i] == o)
                return i;
        return -1;
    endfunction

    function automatic void promote(int s);
        int r;
        r = ent_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (ent_live[i] && ent_age[i] < r)
                ent_age[i]++;
        ent_age[s] = 0;
    endfunction

    function automatic void retire(int s);
        ent_live[s] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_live[i] && ent_age[i] > ent_age[s])
                ent_age[i]--;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_live[i])
                n++;
        return n;
    endfunction

    function automatic int least_recent();
        int b;
        b = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_live[i] && (b < 0 || ent_age[i] > ent_age[b]))
                b = i;
        return b;
    endfunction

    function automatic rsp_t cache_outcome(req_t q);
        rsp_t        o;
        int          s;
        int          gone;
        int          v;
        logic [63:0] t;
        o    = '0;
        gone = 0;
        if (q.action == ACT_LOOKUP)
        begin
            s = find_key(q.file_id, q.block_offset);
            if (s >= 0)
            begin
                promote(s);
                o.found     = 1'b1;
                o.value_out = ent_value[s];
                hit_total++;
            end
            else
                miss_total++;
        end
        else if (q.action == ACT_INSERT)
        begin
            s = find_key(q.file_id, q.block_offset);
            if (s >= 0)
            begin
                promote(s);
                o.found     = 1'b1;
                o.value_out = ent_value[s];
            end
            else
            begin
                if (live_count() >= ENTRIES)
                begin
                    v = least_recent();
                    resident_bytes -= 32'(ent_bytes[v]);
                    retire(v);
                    gone++;
                    evict_total++;
                end
                s = 0;
                while (ent_live[s])
                    s++;
                for (int i = 0; i < ENTRIES; i++)
                    if (ent_live[i])
                        ent_age[i]++;
                ent_live[s]  = 1'b1;
                ent_file[s]  = q.file_id;
                ent_off[s]   = q.block_offset;
                ent_value[s] = q.value_id;
                ent_bytes[s] = q.block_bytes;
                ent_age[s]   = 0;
                t = 64'(resident_bytes) + 64'(q.block_bytes);
                while (t > 64'(budget) && live_count() > 1)
                begin
                    v = least_recent();
                    t -= 64'(ent_bytes[v]);
                    retire(v);
                    gone++;
                    evict_total++;
                end
                resident_bytes = t[31:0];
                o.value_out    = q.value_id;
            end
        end
        else if (q.action == ACT_ERASE)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (ent_live[i] && ent_file[i] == q.file_id)
                begin
                    resident_bytes -= 32'(ent_bytes[i]);
                    retire(i);
                    gone++;
                end
        end
        o.evicted_now    = (gone > 511) ? REMOVED_MAX : 9'(gone);
        o.total_charge   = resident_bytes;
        o.hit_count      = hit_total;
        o.miss_count     = miss_total;
        o.eviction_count = evict_total;
        return o;
    endfunction

    task automatic compare_field(string label, logic [39:0] got, logic [39:0] want);
        if (got !== want)
        begin
            if (fail_count < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result item with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    compare_field("found", 40'(rsp.found), 40'(want.found));
                    compare_field("value_out", 40'(rsp.value_out), 40'(want.value_out));
                    compare_field("evicted_now", 40'(rsp.evicted_now), 40'(want.evicted_now));
                    compare_field("total_charge", 40'(rsp.total_charge),
                                  40'(want.total_charge));
                    compare_field("hit_count", 40'(rsp.hit_count), 40'(want.hit_count));
                    compare_field("miss_count", 40'(rsp.miss_count), 40'(want.miss_count));
                    compare_field("eviction_count", 40'(rsp.eviction_count),
                                  40'(want.eviction_count));
                end
            end
            if (req_valid && !req_stall)
                awaited_rsp.push_back(cache_outcome(req));
            if (cfg_valid && cfg_ready)
                budget = cfg_data;
        end
    end

endmodule

@@ tb/tb_lru_block_cache_with_byte_budget.sv @@
// Top of the testbench for the LRU block cache: clock, reset, request and budget stimulus.
// The receiver stalls on its own pattern; the verdict comes from the checker's counts.
// Depends on lrubc_pkg, the block and lru_block_cache_with_byte_budget_checker.
`timescale 1ns / 100ps

module tb_lru_block_cache_with_byte_budget;
    import lrubc_pkg::*;

    localparam int CYCLE_LIMIT = 30000000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          fail_count;
    int          outstanding;
    int          cycles;
    int          burst_left;

    lru_block_cache_with_byte_budget i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lru_block_cache_with_byte_budget_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("lru_block_cache_with_byte_budget test failed");
                $finish;
            end
        end
    end

    // The receiver stalls at a rate that changes now and then, and once
    // holds off for a long stretch so that the block backs up.
    initial
    begin
        int stall_pct;
        int hold_done;
        stall_pct = 0;
        hold_done = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_done == 0 && cycles > 40000)
            begin
                hold_done = 1;
                rsp_stall <= 1'b1;
                repeat (5000)
                    @(posedge clk);
            end
            if ($urandom_range(0, 299) == 0)
                stall_pct = $urandom_range(0, 2) * 40;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic req_t make_req(logic [1:0] act, logic [31:0] f, logic [39:0] o,
                                      logic [31:0] v, logic [20:0] b);
        req_t q;
        q.action       = act;
        q.file_id      = f;
        q.block_offset = o;
        q.value_id     = v;
        q.block_bytes  = b;
        return q;
    endfunction

    function automatic req_t random_req();
        req_t q;
        int   pick;
        pick           = $urandom_range(0, 99);
        q.file_id      = $urandom_range(0, 15);
        q.block_offset = 40'($urandom_range(0, 31));
        q.value_id     = $urandom;
        q.block_bytes  = 21'($urandom_range(1, 4096));
        if (pick < 45)
            q.action = ACT_INSERT;
        else if (pick < 87)
            q.action = ACT_LOOKUP;
        else if (pick < 90)
            q.action = ACT_ERASE;
        else
        begin
            q.action       = 2'($urandom_range(0, 3));
            q.file_id      = $urandom;
            q.block_offset = {8'($urandom), 32'($urandom)};
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            q.block_bytes = '0;
        else if (pick < 9)
            q.block_bytes = 21'($urandom);
        return q;
    endfunction

    task automatic send_item(req_t q);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        else
            burst_left--;
        req_valid <= 1'b1;
        req       <= q;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic set_budget(logic [31:0] bytes);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= bytes;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] budgets [4];
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        burst_left = 5;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_req(ACT_LOOKUP, 32'd0, 40'd0, 32'd9, 21'd5));
        send_item(make_req(ACT_INSERT, 32'd0, 40'd0, 32'd1, 21'd100));
        send_item(make_req(ACT_INSERT, 32'd0, 40'd0, 32'd2, 21'd300));
        send_item(make_req(ACT_LOOKUP, 32'd0, 40'd0, 32'd0, 21'd0));
        send_item(make_req(ACT_INSERT, '1, '1, '1, '1));
        send_item(make_req(ACT_LOOKUP, '1, '1, '0, '0));
        send_item(make_req(2'd3, '1, '1, '1, '1));
        send_item(make_req(ACT_INSERT, 32'd0, 40'd7, 32'd3, 21'd0));
        send_item(make_req(ACT_INSERT, 32'd5, 40'd1, 32'd4, 21'd1024));
        send_item(make_req(ACT_ERASE, 32'd0, '1, '1, '1));
        send_item(make_req(ACT_ERASE, 32'd77, 40'd0, 32'd0, 21'd0));
        set_budget(32'd0);
        send_item(make_req(ACT_LOOKUP, '1, '1, '0, '0));
        send_item(make_req(ACT_INSERT, 32'd3, 40'd3, 32'd5, 21'd10));
        send_item(make_req(ACT_INSERT, 32'd3, 40'd4, 32'd6, 21'd0));
        send_item(make_req(ACT_LOOKUP, 32'd3, 40'd3, 32'd0, 21'd0));
        set_budget('1);
        send_item(make_req(ACT_INSERT, 32'd6, 40'd2, 32'd7, '1));
        send_item(make_req(ACT_LOOKUP, 32'd6, 40'd2, 32'd0, 21'd0));

        budgets[0] = CAP_RESET;
        budgets[1] = 32'd200000;
        budgets[2] = '1;
        budgets[3] = 32'd0;
        for (int p = 0; p < 4; p++)
        begin
            set_budget(budgets[p]);
            repeat ((p == 3) ? 300 : 570)
                send_item(random_req());
        end
        settle();
        repeat (200)
            @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("lru_block_cache_with_byte_budget test passed");
        else
            $display("lru_block_cache_with_byte_budget test failed");
        $finish;
    end

endmodule
